// ===== design/occ_pkg.sv =====
`default_nettype none
package occ_pkg;

	localparam int ANGLE_STEPS = 4096;
	localparam int ANGLE_W     = $clog2(ANGLE_STEPS);
	// phase = angle * 2^32 / ANGLE_STEPS, a plain shift for a power-of-two step count
	localparam int PH_SHIFT    = 32 - ANGLE_W;
	localparam int ACT_W       = 3;
	localparam int TRIG_W      = 16;

	localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ADD    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POINT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_CIRCLE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_SQUARE = 3'd4;

	// odd sine polynomial over a quarter turn, Q30
	localparam logic [30:0] K1 = 31'd1686629713;
	localparam logic [30:0] K3 = 31'd693598668;
	localparam logic [30:0] K5 = 31'd85569306;
	localparam logic [30:0] K7 = 31'd5026995;
	localparam logic [30:0] K9 = 31'd172272;
	localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
	localparam logic [16:0] TRIG_ONE = 17'd16384;

	typedef logic [3:0] tstep_t;
	localparam tstep_t TS_LOAD  = 4'd0;
	localparam tstep_t TS_SQR   = 4'd1;
	localparam tstep_t TS_T2    = 4'd2;
	localparam tstep_t TS_M7    = 4'd3;
	localparam tstep_t TS_A7    = 4'd4;
	localparam tstep_t TS_M5    = 4'd5;
	localparam tstep_t TS_A5    = 4'd6;
	localparam tstep_t TS_M3    = 4'd7;
	localparam tstep_t TS_A3    = 4'd8;
	localparam tstep_t TS_M1    = 4'd9;
	localparam tstep_t TS_A1    = 4'd10;
	localparam tstep_t TS_MU    = 4'd11;
	localparam tstep_t TS_ROUND = 4'd12;

	typedef struct packed {
		logic [31:0] left;
		logic [31:0] bottom;
		logic [30:0] width;
		logic [30:0] height;
	} obs_t;

	typedef struct packed {
		logic   load;
		logic   clear;
		logic   add;
		logic   trig_en;
		logic   trig_cos;
		tstep_t trig_k;
		logic   prep0;
		logic   prep1;
		logic   idx_clr;
		logic   rd;
		logic   out_load;
	} cmd_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             empty;
		logic             last;
		logic             pipe_empty;
	} sts_t;

endpackage
`default_nettype wire

// ===== design/occ_ctrl.sv =====
`default_nettype none
module occ_ctrl import occ_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_fire,
	input  wire logic m_tready,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output logic      s_tready,
	output logic      m_tvalid
);

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b00000001,
		ST_EXEC  = 8'b00000010,
		ST_TRIG  = 8'b00000100,
		ST_PREP0 = 8'b00001000,
		ST_PREP1 = 8'b00010000,
		ST_SCAN  = 8'b00100000,
		ST_DRAIN = 8'b01000000,
		ST_DONE  = 8'b10000000
	} state_t;

	state_t         state_q, state_d;
	tstep_t         k_q, k_d;
	logic           cos_q, cos_d;
	logic           out_vld_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;

	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		cos_d   = cos_q;
		cmd     = '0;
		cmd.load     = s_fire;
		cmd.trig_k   = k_q;
		cmd.trig_cos = cos_q;
		case (state_q)
			ST_IDLE: begin
				if (s_fire) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				case (sts.action)
					ACT_CLEAR: begin
						cmd.clear = 1'b1;
						state_d   = ST_DONE;
					end
					ACT_ADD: begin
						cmd.add = 1'b1;
						state_d = ST_DONE;
					end
					ACT_POINT, ACT_CIRCLE: state_d = ST_PREP0;
					ACT_SQUARE: begin
						k_d     = TS_LOAD;
						cos_d   = 1'b0;
						state_d = ST_TRIG;
					end
					default: state_d = ST_DONE;
				endcase
			end
			ST_TRIG: begin
				cmd.trig_en = 1'b1;
				if (k_q == TS_ROUND) begin
					k_d   = TS_LOAD;
					cos_d = 1'b1;
					if (cos_q) state_d = ST_PREP0;
				end else begin
					k_d = k_q + 4'd1;
				end
			end
			ST_PREP0: begin
				cmd.prep0 = 1'b1;
				state_d   = ST_PREP1;
			end
			ST_PREP1: begin
				cmd.prep1   = 1'b1;
				cmd.idx_clr = 1'b1;
				state_d     = sts.empty ? ST_DRAIN : ST_SCAN;
			end
			ST_SCAN: begin
				cmd.rd = 1'b1;
				if (sts.last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_vld_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= TS_LOAD;
			cos_q     <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			cos_q   <= cos_d;
			if (cmd.out_load) out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== design/occ_dp.sv =====
`default_nettype none
module occ_dp import occ_pkg::*; #(
	parameter int MAX_OBSTACLES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmd_t               cmd,
	input  wire logic [ACT_W-1:0]   action,
	input  wire logic [31:0]        pos_x,
	input  wire logic [31:0]        pos_y,
	input  wire logic [30:0]        size_a,
	input  wire logic [30:0]        size_b,
	input  wire logic [ANGLE_W-1:0] angle,
	output sts_t                    sts,
	output logic                    is_free,
	output logic                    table_full
);

	localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
	localparam int CW = $clog2(MAX_OBSTACLES + 1);
	localparam int CORN_W = 50;
	localparam int PW = 50;
	localparam int LW = 52;

	// query
	logic [ACT_W-1:0]   act_q;
	logic signed [31:0] x_q, y_q;
	logic [30:0]        a_q, b_q;

	// table
	obs_t        mem [MAX_OBSTACLES];
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] idx_q;
	logic          full;
	logic          full_q;
	logic          hit_q;

	assign full = (cnt_q == CW'(MAX_OBSTACLES));

	// phase = angle * 2^32 / ANGLE_STEPS
	logic [31:0]        ph_q;

	// sine/cosine evaluation on one shared multiplier
	logic [30:0]  u_q, s_q, t2_q;
	logic         neg_q;
	logic [61:0]  prod_q;
	logic [30:0]  mul_a, mul_b;
	logic [61:0]  mul_p;
	logic [31:0]  phase;
	logic [30:0]  u_next;
	logic [30:0]  p_hi;
	logic [32:0]  rsum;
	logic [16:0]  rnd;
	logic [16:0]  mag;
	logic signed [TRIG_W-1:0] trig_val;
	logic signed [TRIG_W-1:0] sin_q, cos_q;

	assign phase  = cmd.trig_cos ? (ph_q + 32'h4000_0000) : ph_q;
	assign u_next = phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
	assign p_hi   = prod_q[60:30];
	assign rsum   = {1'b0, prod_q[61:30]} + 33'd32768;
	assign rnd    = rsum[32:16];
	assign mag    = (rnd > TRIG_ONE) ? TRIG_ONE : rnd;
	assign trig_val = neg_q ? TRIG_W'(-$signed(mag)) : TRIG_W'(mag);

	always_comb begin
		mul_a = s_q;
		mul_b = t2_q;
		case (cmd.trig_k)
			TS_SQR: begin
				mul_a = u_q;
				mul_b = u_q;
			end
			TS_MU: mul_b = u_q;
			default: ;
		endcase
	end
	assign mul_p = 62'(mul_a) * 62'(mul_b);

	// per-query constants
	logic [61:0]              r2_q;
	logic signed [48:0]       pp_q, pm_q;
	logic signed [16:0]       cps, cms;
	logic signed [CORN_W-1:0] cx_q [4];
	logic signed [CORN_W-1:0] cy_q [4];
	logic signed [CORN_W-1:0] xsh, ysh, opp, opm;

	assign cps = 17'(cos_q) + 17'(sin_q);
	assign cms = 17'(cos_q) - 17'(sin_q);
	assign xsh = CORN_W'($signed({x_q, 15'd0}));
	assign ysh = CORN_W'($signed({y_q, 15'd0}));
	assign opp = CORN_W'(pp_q);
	assign opm = CORN_W'(pm_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			x_q   <= pos_x;
			y_q   <= pos_y;
			a_q   <= size_a;
			b_q   <= size_b;
			ph_q  <= 32'(angle) << PH_SHIFT;
		end
		if (cmd.trig_en) begin
			case (cmd.trig_k)
				TS_LOAD: begin
					u_q   <= u_next;
					neg_q <= phase[31];
					s_q   <= K9;
				end
				TS_SQR, TS_M7, TS_M5, TS_M3, TS_M1, TS_MU: prod_q <= mul_p;
				TS_T2: t2_q <= p_hi;
				TS_A7: s_q <= K7 - p_hi;
				TS_A5: s_q <= K5 - p_hi;
				TS_A3: s_q <= K3 - p_hi;
				TS_A1: s_q <= K1 - p_hi;
				TS_ROUND: begin
					if (cmd.trig_cos) cos_q <= trig_val;
					else sin_q <= trig_val;
				end
				default: ;
			endcase
		end
		if (cmd.prep0) begin
			r2_q <= 62'(a_q) * 62'(a_q);
			pp_q <= 49'($signed({1'b0, a_q})) * 49'(cps);
			pm_q <= 49'($signed({1'b0, a_q})) * 49'(cms);
		end
		if (cmd.prep1) begin
			// square corners in the order (-,-) (+,-) (+,+) (-,+)
			cx_q[0] <= xsh - opm;
			cy_q[0] <= ysh - opp;
			cx_q[1] <= xsh + opp;
			cy_q[1] <= ysh - opm;
			cx_q[2] <= xsh + opm;
			cy_q[2] <= ysh + opp;
			cx_q[3] <= xsh - opp;
			cy_q[3] <= ysh + opm;
		end
	end

	// table memory, registered read
	obs_t ent_s1;
	always_ff @(posedge clk) begin
		if (cmd.add && !full) mem[cnt_q[AW-1:0]] <= {x_q, y_q, a_q, b_q};
		if (cmd.rd) ent_s1 <= mem[idx_q];
	end

	// stage 2: bounds, circle gaps, corner tests, frame products
	logic signed [33:0] l34, b34, r34, t34, x34, y34, dx0, dy0;
	logic               pt_hit;
	logic [3:0]         cpt;
	logic signed [CORN_W-1:0] lsh, rsh, bsh, tsh;
	logic [32:0]        gx, gy;

	assign l34 = 34'($signed(ent_s1.left));
	assign b34 = 34'($signed(ent_s1.bottom));
	assign r34 = l34 + $signed({3'b000, ent_s1.width});
	assign t34 = b34 + $signed({3'b000, ent_s1.height});
	assign x34 = 34'(x_q);
	assign y34 = 34'(y_q);
	assign dx0 = l34 - x34;
	assign dy0 = b34 - y34;
	assign pt_hit = (x34 >= l34) && (x34 <= r34) && (y34 >= b34) && (y34 <= t34);
	assign gx = (x34 < l34) ? 33'(l34 - x34) : ((x34 > r34) ? 33'(x34 - r34) : 33'd0);
	assign gy = (y34 < b34) ? 33'(b34 - y34) : ((y34 > t34) ? 33'(y34 - t34) : 33'd0);
	assign lsh = CORN_W'($signed({l34, 15'd0}));
	assign rsh = CORN_W'($signed({r34, 15'd0}));
	assign bsh = CORN_W'($signed({b34, 15'd0}));
	assign tsh = CORN_W'($signed({t34, 15'd0}));

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			cpt[k] = (cx_q[k] >= lsh) && (cx_q[k] <= rsh) &&
				(cy_q[k] >= bsh) && (cy_q[k] <= tsh);
		end
	end

	logic              pt_s2, sqp_s2;
	logic [32:0]       gx_s2, gy_s2;
	logic signed [PW-1:0] dxc_s2, dxs_s2, dyc_s2, dys_s2, wc_s2, ws_s2, hc_s2, hs_s2;

	always_ff @(posedge clk) begin
		pt_s2  <= pt_hit;
		sqp_s2 <= |cpt;
		gx_s2  <= gx;
		gy_s2  <= gy;
		dxc_s2 <= PW'(dx0) * PW'(cos_q);
		dxs_s2 <= PW'(dx0) * PW'(sin_q);
		dyc_s2 <= PW'(dy0) * PW'(cos_q);
		dys_s2 <= PW'(dy0) * PW'(sin_q);
		wc_s2  <= PW'($signed({1'b0, ent_s1.width})) * PW'(cos_q);
		ws_s2  <= PW'($signed({1'b0, ent_s1.width})) * PW'(sin_q);
		hc_s2  <= PW'($signed({1'b0, ent_s1.height})) * PW'(cos_q);
		hs_s2  <= PW'($signed({1'b0, ent_s1.height})) * PW'(sin_q);
	end

	// stage 3: squared gaps, rectangle corners in the square's frame
	logic              pt_s3, sqp_s3, far_s3;
	logic [61:0]       gx2_s3, gy2_s3;
	logic signed [LW-1:0] lx_s3 [4];
	logic signed [LW-1:0] ly_s3 [4];
	logic signed [LW-1:0] lx0, ly0;

	assign lx0 = LW'(dxc_s2) + LW'(dys_s2);
	assign ly0 = LW'(dyc_s2) - LW'(dxs_s2);

	always_ff @(posedge clk) begin
		pt_s3    <= pt_s2;
		sqp_s3   <= sqp_s2;
		far_s3   <= (gx_s2 >= {2'b00, a_q}) || (gy_s2 >= {2'b00, a_q});
		gx2_s3   <= 62'(gx_s2[30:0]) * 62'(gx_s2[30:0]);
		gy2_s3   <= 62'(gy_s2[30:0]) * 62'(gy_s2[30:0]);
		lx_s3[0] <= lx0;
		ly_s3[0] <= ly0;
		lx_s3[1] <= lx0 + LW'(wc_s2);
		ly_s3[1] <= ly0 - LW'(ws_s2);
		lx_s3[2] <= lx0 + LW'(wc_s2) + LW'(hs_s2);
		ly_s3[2] <= ly0 + LW'(hc_s2) - LW'(ws_s2);
		lx_s3[3] <= lx0 + LW'(hs_s2);
		ly_s3[3] <= ly0 + LW'(hc_s2);
	end

	// stage 4: final compares
	logic              pt_s4, sqp_s4, circ_s4;
	logic [3:0]        ocr_s4;
	logic [LW-1:0]     lim;
	logic [3:0]        ocr;

	assign lim = {8'd0, a_q, 13'd0};

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			ocr[k] = ($unsigned(lx_s3[k][LW-1] ? -lx_s3[k] : lx_s3[k]) <= lim) &&
				($unsigned(ly_s3[k][LW-1] ? -ly_s3[k] : ly_s3[k]) <= lim);
		end
	end

	always_ff @(posedge clk) begin
		pt_s4   <= pt_s3;
		sqp_s4  <= sqp_s3;
		ocr_s4  <= ocr;
		circ_s4 <= !far_s3 && (({1'b0, gx2_s3} + {1'b0, gy2_s3}) < {1'b0, r2_q});
	end

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic hit_now;

	always_comb begin
		case (act_q)
			ACT_POINT:  hit_now = pt_s4;
			ACT_CIRCLE: hit_now = circ_s4;
			default:    hit_now = sqp_s4 || (|ocr_s4);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			full_q <= 1'b0;
			hit_q  <= 1'b0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			if (cmd.load) full_q <= 1'b0;
			if (cmd.clear) cnt_q <= '0;
			if (cmd.add) begin
				if (full) full_q <= 1'b1;
				else cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.rd) idx_q <= idx_q + AW'(1);
			if (cmd.prep0) hit_q <= 1'b0;
			else if (vld_s4 && hit_now) hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			is_free    <= ((act_q == ACT_POINT) || (act_q == ACT_CIRCLE) ||
				(act_q == ACT_SQUARE)) && !hit_q;
			table_full <= full_q;
		end
	end

	assign sts.action     = act_q;
	assign sts.empty      = (cnt_q == '0);
	assign sts.last       = ((CW'(idx_q) + CW'(1)) == cnt_q);
	assign sts.pipe_empty = !(vld_s1 || vld_s2 || vld_s3 || vld_s4);

endmodule
`default_nettype wire

// ===== design/obstacle_collision_checker_top.sv =====
// Point and circle queries scan all N stored obstacles; an empty table skips the scan.
// Square queries first run two sine/cosine evaluations on one shared multiplier.
// The scan reads one obstacle per cycle from the table memory into a 4-stage test pipe.
// Clear, add and unknown actions need no scan. One request is in work at a time; the next is
// taken in the cycle after the result register loads; a stalled result holds back the next result.
// Reset (arst_n low) empties the table and drops any pending result; table contents are not cleared.
`default_nettype none
module obstacle_collision_checker_top import occ_pkg::*; #(
	parameter int MAX_OBSTACLES = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [143:0] s_tdata,  // pos_x[31:0], pos_y[63:32], size_a[94:64],
	                                    // size_b[125:95], angle[137:126], zero pad
	input  wire logic [2:0]   s_tuser,  // action[2:0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [7:0]        m_tdata   // is_free[0], table_full[1], zero pad
);

	cmd_t cmd;
	sts_t sts;
	logic is_free, table_full;

	occ_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_fire   (s_tvalid && s_tready),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid)
	);

	occ_dp #(
		.MAX_OBSTACLES (MAX_OBSTACLES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.action     (s_tuser),
		.pos_x      (s_tdata[31:0]),
		.pos_y      (s_tdata[63:32]),
		.size_a     (s_tdata[94:64]),
		.size_b     (s_tdata[125:95]),
		.angle      (s_tdata[137:126]),
		.sts        (sts),
		.is_free    (is_free),
		.table_full (table_full)
	);

	assign m_tdata = {6'd0, table_full, is_free};

endmodule
`default_nettype wire

// ===== design/occ_chk.sv =====
`default_nettype none
module occ_chk (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata
);

	// one request in work: input closes right after a request
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after accepting a request");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed or dropped");

	// a failed add is never reported as free
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("is_free and table_full both set");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !$isunknown(m_tdata))
		else $error("result data unknown while valid");

endmodule

bind obstacle_collision_checker_top occ_chk u_occ_chk (.*);
`default_nettype wire
